@@ hdl/cnwt_pkg.sv @@
`timescale 1ns / 1ps

package cnwt_pkg;

    localparam int MAX_DIGITS_DEF = 16;
    localparam int STORE_DEPTH    = 16;
    localparam int ADDR_W         = 4;
    localparam int CNT_W          = 5;
    localparam int DIGIT_W        = 4;
    localparam int WORD_W         = 6;
    localparam int GROUP_DIGITS   = 6;
    localparam int SLOT_W         = 3;
    localparam int NUM_SLOTS      = 7;

    // word codes
    localparam logic [WORD_W-1:0] W_FEM_ONE    = 6'd10;
    localparam logic [WORD_W-1:0] W_FEM_TWO    = 6'd11;
    localparam logic [WORD_W-1:0] W_TEEN       = 6'd12;
    localparam logic [WORD_W-1:0] W_TENS       = 6'd22;
    localparam logic [WORD_W-1:0] W_HUND       = 6'd30;
    localparam logic [WORD_W-1:0] W_THOUS_SG   = 6'd39;
    localparam logic [WORD_W-1:0] W_THOUS_FEW  = 6'd40;
    localparam logic [WORD_W-1:0] W_THOUS_MANY = 6'd41;

    // output word source
    localparam logic [1:0] SEL_PASS  = 2'd0;
    localparam logic [1:0] SEL_SPELL = 2'd1;
    localparam logic [1:0] SEL_NUM   = 2'd2;

    typedef struct packed {
        logic       capture;
        logic       finish;
        logic       idx_clear;
        logic       idx_step;
        logic       load_out;
        logic [1:0] out_sel;
    } cmd_t;

    typedef struct packed {
        logic pass_needed;
        logic spell_mode;
        logic out_free;
        logic slot_present;
        logic slot_is_last;
        logic spell_is_last;
    } status_t;

endpackage

@@ hdl/cardinal_number_to_word_tokens.sv @@
`timescale 1ns / 1ps

// Ukrainian cardinal number to word codes. Digits enter one per cycle, most
// significant first, the final one marked by last_digit; the digit port then
// stalls until every word of that number has been loaded into the output
// register. After the final digit a decide state picks the form, then words
// follow: a spelled-out number (leading zero, two or more digits) reads each
// digit from the registered digit store in a read state, then loads it in a
// write state; a cardinal value steps through seven fixed word slots,
// skipping empty ones; an out-of-range or non-decimal number gives one
// pass-through transaction. Every word load waits while the output register
// is held by word_stall.
module cardinal_number_to_word_tokens
#(
    parameter int MAX_DIGITS = cnwt_pkg::MAX_DIGITS_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           digit_valid,
    output logic                           digit_stall,
    input  logic [cnwt_pkg::DIGIT_W-1:0]   digit,
    input  logic                           last_digit,
    output logic                           word_valid,
    input  logic                           word_stall,
    output logic [cnwt_pkg::WORD_W-1:0]    word_code,
    output logic                           last_word,
    output logic                           pass_through
);

    cnwt_pkg::cmd_t    cmd;
    cnwt_pkg::status_t status;

    cnwt_ctrl u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .digit_valid (digit_valid),
        .last_digit  (last_digit),
        .status      (status),
        .digit_stall (digit_stall),
        .cmd         (cmd)
    );

    cnwt_datapath
    #(
        .MAX_DIGITS (MAX_DIGITS)
    )
    u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .digit        (digit),
        .word_stall   (word_stall),
        .status       (status),
        .word_valid   (word_valid),
        .word_code    (word_code),
        .last_word    (last_word),
        .pass_through (pass_through)
    );

endmodule

@@ hdl/cnwt_ctrl.sv @@
`timescale 1ns / 1ps

module cnwt_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              digit_valid,
    input  logic              last_digit,
    input  cnwt_pkg::status_t status,
    output logic              digit_stall,
    output cnwt_pkg::cmd_t    cmd
);

    localparam logic [2:0] ST_COLLECT  = 3'd0;
    localparam logic [2:0] ST_DECIDE   = 3'd1;
    localparam logic [2:0] ST_PASS     = 3'd2;
    localparam logic [2:0] ST_SPELL_RD = 3'd3;
    localparam logic [2:0] ST_SPELL_WR = 3'd4;
    localparam logic [2:0] ST_NUM      = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign digit_stall = (state_reg != ST_COLLECT);

    always_comb
    begin
        state_next    = state_reg;
        cmd.capture   = 1'b0;
        cmd.finish    = 1'b0;
        cmd.idx_clear = 1'b0;
        cmd.idx_step  = 1'b0;
        cmd.load_out  = 1'b0;
        cmd.out_sel   = cnwt_pkg::SEL_PASS;
        case (state_reg)
            ST_COLLECT:
            begin
                if (digit_valid)
                begin
                    cmd.capture = 1'b1;
                    if (last_digit)
                    begin
                        state_next = ST_DECIDE;
                    end
                end
            end
            ST_DECIDE:
            begin
                cmd.idx_clear = 1'b1;
                if (status.pass_needed)
                begin
                    state_next = ST_PASS;
                end
                else if (status.spell_mode)
                begin
                    state_next = ST_SPELL_RD;
                end
                else
                begin
                    state_next = ST_NUM;
                end
            end
            ST_PASS:
            begin
                cmd.out_sel = cnwt_pkg::SEL_PASS;
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    cmd.finish   = 1'b1;
                    state_next   = ST_COLLECT;
                end
            end
            ST_SPELL_RD:
            begin
                // store read data lands next cycle
                state_next = ST_SPELL_WR;
            end
            ST_SPELL_WR:
            begin
                cmd.out_sel = cnwt_pkg::SEL_SPELL;
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    if (status.spell_is_last)
                    begin
                        cmd.finish = 1'b1;
                        state_next = ST_COLLECT;
                    end
                    else
                    begin
                        cmd.idx_step = 1'b1;
                        state_next   = ST_SPELL_RD;
                    end
                end
            end
            ST_NUM:
            begin
                cmd.out_sel = cnwt_pkg::SEL_NUM;
                if (!status.slot_present)
                begin
                    cmd.idx_step = 1'b1;
                end
                else if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    if (status.slot_is_last)
                    begin
                        cmd.finish = 1'b1;
                        state_next = ST_COLLECT;
                    end
                    else
                    begin
                        cmd.idx_step = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_COLLECT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ hdl/cnwt_datapath.sv @@
`timescale 1ns / 1ps

module cnwt_datapath
#(
    parameter int MAX_DIGITS = cnwt_pkg::MAX_DIGITS_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  cnwt_pkg::cmd_t                     cmd,
    input  logic [cnwt_pkg::DIGIT_W-1:0]       digit,
    input  logic                               word_stall,
    output cnwt_pkg::status_t                  status,
    output logic                               word_valid,
    output logic [cnwt_pkg::WORD_W-1:0]        word_code,
    output logic                               last_word,
    output logic                               pass_through
);

    localparam int LIMIT = (MAX_DIGITS < cnwt_pkg::STORE_DEPTH) ?
                           MAX_DIGITS : cnwt_pkg::STORE_DEPTH;

    logic [cnwt_pkg::DIGIT_W-1:0] store_mem [cnwt_pkg::STORE_DEPTH];
    logic [cnwt_pkg::DIGIT_W-1:0] rd_data_reg;

    logic [cnwt_pkg::CNT_W-1:0]   count_reg, count_next;
    logic                         too_many_reg, too_many_next;
    logic                         bad_reg, bad_next;
    logic                         lead_zero_reg, lead_zero_next;
    logic [cnwt_pkg::ADDR_W-1:0]  idx_reg, idx_next;
    logic [cnwt_pkg::DIGIT_W-1:0] dig_reg [cnwt_pkg::GROUP_DIGITS];
    logic [cnwt_pkg::DIGIT_W-1:0] dig_next [cnwt_pkg::GROUP_DIGITS];

    logic                         word_valid_reg, word_valid_next;
    logic [cnwt_pkg::WORD_W-1:0]  word_code_reg, word_code_next;
    logic                         last_word_reg, last_word_next;
    logic                         pass_reg, pass_next;

    logic                         store_ok;
    logic [cnwt_pkg::NUM_SLOTS-1:0] present;
    logic [cnwt_pkg::WORD_W-1:0]  slot_code;
    logic [cnwt_pkg::SLOT_W-1:0]  slot;
    logic                         value_zero;
    logic [cnwt_pkg::WORD_W-1:0]  d0, d1, d2, d3, d4, d5;
    logic [cnwt_pkg::WORD_W-1:0]  fem_code, noun_code;

    assign store_ok = (count_reg < cnwt_pkg::CNT_W'(LIMIT));
    assign slot     = idx_reg[cnwt_pkg::SLOT_W-1:0];

    // dig_reg[0] holds the units digit
    assign d0 = cnwt_pkg::WORD_W'(dig_reg[0]);
    assign d1 = cnwt_pkg::WORD_W'(dig_reg[1]);
    assign d2 = cnwt_pkg::WORD_W'(dig_reg[2]);
    assign d3 = cnwt_pkg::WORD_W'(dig_reg[3]);
    assign d4 = cnwt_pkg::WORD_W'(dig_reg[4]);
    assign d5 = cnwt_pkg::WORD_W'(dig_reg[5]);

    assign value_zero = (d0 == '0) && (d1 == '0) && (d2 == '0) &&
                        (d3 == '0) && (d4 == '0) && (d5 == '0);

    always_comb
    begin
        if (d3 == 6'd1)
        begin
            fem_code = cnwt_pkg::W_FEM_ONE;
        end
        else if (d3 == 6'd2)
        begin
            fem_code = cnwt_pkg::W_FEM_TWO;
        end
        else
        begin
            fem_code = d3;
        end
        // teens of the thousands group always take the genitive plural
        if (d4 == 6'd1)
        begin
            noun_code = cnwt_pkg::W_THOUS_MANY;
        end
        else if (d3 == 6'd1)
        begin
            noun_code = cnwt_pkg::W_THOUS_SG;
        end
        else if ((d3 == 6'd2) || (d3 == 6'd3) || (d3 == 6'd4))
        begin
            noun_code = cnwt_pkg::W_THOUS_FEW;
        end
        else
        begin
            noun_code = cnwt_pkg::W_THOUS_MANY;
        end
    end

    // slots in output order: thousands hundreds, tens, units, noun,
    // then hundreds, tens, units of the low group
    always_comb
    begin
        present[0] = (d5 != '0);
        present[1] = (d4 != '0);
        present[2] = (d4 != 6'd1) && (d3 != '0);
        present[3] = (d5 != '0) || (d4 != '0) || (d3 != '0);
        present[4] = (d2 != '0);
        present[5] = (d1 != '0);
        present[6] = ((d1 != 6'd1) && (d0 != '0)) || value_zero;
    end

    always_comb
    begin
        case (slot)
            3'd0:    slot_code = cnwt_pkg::W_HUND - 6'd1 + d5;
            3'd1:    slot_code = (d4 == 6'd1) ? (cnwt_pkg::W_TEEN + d3)
                                              : (cnwt_pkg::W_TENS - 6'd2 + d4);
            3'd2:    slot_code = fem_code;
            3'd3:    slot_code = noun_code;
            3'd4:    slot_code = cnwt_pkg::W_HUND - 6'd1 + d2;
            3'd5:    slot_code = (d1 == 6'd1) ? (cnwt_pkg::W_TEEN + d0)
                                              : (cnwt_pkg::W_TENS - 6'd2 + d1);
            3'd6:    slot_code = d0;
            default: slot_code = '0;
        endcase
    end

    always_comb
    begin
        status.spell_mode    = (count_reg > cnwt_pkg::CNT_W'(1)) && lead_zero_reg;
        status.pass_needed   = too_many_reg || bad_reg ||
                               (!status.spell_mode &&
                                (count_reg > cnwt_pkg::CNT_W'(cnwt_pkg::GROUP_DIGITS)));
        status.out_free      = !word_valid_reg || !word_stall;
        status.slot_present  = (slot < cnwt_pkg::SLOT_W'(cnwt_pkg::NUM_SLOTS)) &&
                               present[slot];
        status.slot_is_last  = ((present >> ({1'b0, slot} + 4'd1)) == '0);
        status.spell_is_last = ((cnwt_pkg::CNT_W'(idx_reg) + cnwt_pkg::CNT_W'(1))
                                == count_reg);
    end

    always_comb
    begin
        count_next     = count_reg;
        too_many_next  = too_many_reg;
        bad_next       = bad_reg;
        lead_zero_next = lead_zero_reg;
        idx_next       = idx_reg;
        for (int i = 0; i < cnwt_pkg::GROUP_DIGITS; i++)
        begin
            dig_next[i] = dig_reg[i];
        end
        if (cmd.capture)
        begin
            if (store_ok)
            begin
                count_next = count_reg + cnwt_pkg::CNT_W'(1);
                if (digit > 4'd9)
                begin
                    bad_next = 1'b1;
                end
                if (count_reg == '0)
                begin
                    lead_zero_next = (digit == '0);
                end
                for (int i = cnwt_pkg::GROUP_DIGITS - 1; i > 0; i--)
                begin
                    dig_next[i] = dig_reg[i-1];
                end
                dig_next[0] = digit;
            end
            else
            begin
                too_many_next = 1'b1;
            end
        end
        if (cmd.finish)
        begin
            count_next     = '0;
            too_many_next  = 1'b0;
            bad_next       = 1'b0;
            lead_zero_next = 1'b0;
            for (int i = 0; i < cnwt_pkg::GROUP_DIGITS; i++)
            begin
                dig_next[i] = '0;
            end
        end
        if (cmd.idx_clear)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_step)
        begin
            idx_next = idx_reg + cnwt_pkg::ADDR_W'(1);
        end
    end

    always_comb
    begin
        word_valid_next = word_valid_reg;
        word_code_next  = word_code_reg;
        last_word_next  = last_word_reg;
        pass_next       = pass_reg;
        if (cmd.load_out)
        begin
            word_valid_next = 1'b1;
            case (cmd.out_sel)
                cnwt_pkg::SEL_PASS:
                begin
                    word_code_next = '0;
                    last_word_next = 1'b1;
                    pass_next      = 1'b1;
                end
                cnwt_pkg::SEL_SPELL:
                begin
                    word_code_next = cnwt_pkg::WORD_W'(rd_data_reg);
                    last_word_next = status.spell_is_last;
                    pass_next      = 1'b0;
                end
                cnwt_pkg::SEL_NUM:
                begin
                    word_code_next = slot_code;
                    last_word_next = status.slot_is_last;
                    pass_next      = 1'b0;
                end
                default:
                begin
                    word_code_next = '0;
                    last_word_next = 1'b1;
                    pass_next      = 1'b1;
                end
            endcase
        end
        else if (!word_stall)
        begin
            word_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture && store_ok)
        begin
            store_mem[count_reg[cnwt_pkg::ADDR_W-1:0]] <= digit;
        end
        rd_data_reg <= store_mem[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        word_code_reg <= word_code_next;
        last_word_reg <= last_word_next;
        pass_reg      <= pass_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            too_many_reg   <= 1'b0;
            bad_reg        <= 1'b0;
            lead_zero_reg  <= 1'b0;
            idx_reg        <= '0;
            word_valid_reg <= 1'b0;
            for (int i = 0; i < cnwt_pkg::GROUP_DIGITS; i++)
            begin
                dig_reg[i] <= '0;
            end
        end
        else
        begin
            count_reg      <= count_next;
            too_many_reg   <= too_many_next;
            bad_reg        <= bad_next;
            lead_zero_reg  <= lead_zero_next;
            idx_reg        <= idx_next;
            word_valid_reg <= word_valid_next;
            for (int i = 0; i < cnwt_pkg::GROUP_DIGITS; i++)
            begin
                dig_reg[i] <= dig_next[i];
            end
        end
    end

    assign word_valid   = word_valid_reg;
    assign word_code    = word_code_reg;
    assign last_word    = last_word_reg;
    assign pass_through = pass_reg;

endmodule
